/* src/u8gt_pkg.sv */
// ----------------------------------------------------------------------------
// u8gt_pkg: shared types and constants for the UTF-8 grid symbol tokenizer
// Beat payload structs, coordinate width, byte codes and lead-byte decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8gt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};

  localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_CR      = 8'h0D;

  localparam logic [7:0] MASK_1B = 8'b10000000;
  localparam logic [7:0] MASK_2B = 8'b11100000;
  localparam logic [7:0] LEAD_2B = 8'b11000000;
  localparam logic [7:0] MASK_3B = 8'b11110000;
  localparam logic [7:0] LEAD_3B = 8'b11100000;
  localparam logic [7:0] MASK_4B = 8'b11111000;
  localparam logic [7:0] LEAD_4B = 8'b11110000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] row;
    logic [COORD_WIDTH-1:0] column;
    logic [31:0]            symbol_bytes;
    logic [2:0]             symbol_length;
  } out_beat_t;

  // Bytes that still follow a lead byte (symbol length minus one).
  function automatic logic [1:0] lead_trail(input logic [7:0] b);
    logic [1:0] r;
    if ((b & MASK_1B) == 8'h00)         r = 2'd0;
    else if ((b & MASK_2B) == LEAD_2B)  r = 2'd1;
    else if ((b & MASK_3B) == LEAD_3B)  r = 2'd2;
    else if ((b & MASK_4B) == LEAD_4B)  r = 2'd3;
    else                                r = 2'd0;
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_inc(input logic [COORD_WIDTH-1:0] v);
    logic [COORD_WIDTH-1:0] r;
    r = (v == COORD_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

/* src/utf8_grid_symbol_tokenizer.sv */
// ----------------------------------------------------------------------------
// utf8_grid_symbol_tokenizer: UTF-8 symbol splitter with row/column tagging
// Gathers lead and continuation bytes, emits non-blank symbols with position.
// ----------------------------------------------------------------------------
// Output: a symbol is registered onto out_* from the beat that ends it.
// Throughput: one byte per cycle unless out_* is held by low out_ready; gather
// state updates on accept; the single output register frees when it is taken.
// Reset: synchronous active-low rst_n clears gather state, row and column and
// drops out_valid; no clearing pass.
`timescale 1ns / 1ps

module utf8_grid_symbol_tokenizer
  import u8gt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [1:0]             rem_r, rem_nxt;
  logic [31:0]            buf_r, buf_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [COORD_WIDTH-1:0] col_r, col_nxt;
  logic [COORD_WIDTH-1:0] row_r, row_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_beat_t              out_data_r, out_data_nxt;

  logic        in_fire;
  logic [7:0]  b;
  logic        last;
  logic        is_nl;
  logic        is_cont;
  logic [31:0] g_buf;
  logic [2:0]  g_cnt;
  logic [1:0]  g_rem;
  logic        fin;
  logic        blank;
  logic        emit;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign last     = in_data.end_of_text;
  assign is_nl    = (b == BYTE_NEWLINE);
  assign is_cont  = (rem_r != 2'd0) && (cnt_r >= 3'd1) && (cnt_r <= 3'd3);

  // gather state after this byte, before any finish
  always_comb begin
    g_buf = buf_r;
    g_cnt = cnt_r;
    g_rem = rem_r;
    if (is_nl) begin
      g_buf = buf_r;
    end else if (is_cont) begin
      case (cnt_r[1:0])
        2'd1:    g_buf = buf_r | {16'h0000, b, 8'h00};
        2'd2:    g_buf = buf_r | {8'h00, b, 16'h0000};
        2'd3:    g_buf = buf_r | {b, 24'h000000};
        default: g_buf = buf_r;
      endcase
      g_cnt = cnt_r + 3'd1;
      g_rem = rem_r - 2'd1;
    end else begin
      g_buf = {24'h000000, b};
      g_cnt = 3'd1;
      g_rem = lead_trail(b);
    end
  end

  // newline, completed symbol or end of text all close the symbol
  assign fin   = is_nl || (g_rem == 2'd0) || last;
  assign blank = (g_cnt == 3'd1) &&
                 ((g_buf[7:0] == BYTE_SPACE) || (g_buf[7:0] == BYTE_TAB) ||
                  (g_buf[7:0] == BYTE_CR));
  assign emit  = fin && (g_cnt != 3'd0) && !blank;

  always_comb begin
    rem_nxt       = rem_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      if (emit) begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.row           = row_r;
        out_data_nxt.column        = col_r;
        out_data_nxt.symbol_bytes  = g_buf;
        out_data_nxt.symbol_length = g_cnt;
      end
      if (last) begin
        rem_nxt = 2'd0;
        buf_nxt = 32'h0;
        cnt_nxt = 3'd0;
        col_nxt = '0;
        row_nxt = '0;
      end else if (is_nl) begin
        rem_nxt = 2'd0;
        buf_nxt = 32'h0;
        cnt_nxt = 3'd0;
        col_nxt = '0;
        row_nxt = sat_inc(row_r);
      end else if (fin) begin
        rem_nxt = 2'd0;
        buf_nxt = 32'h0;
        cnt_nxt = 3'd0;
        col_nxt = sat_inc(col_r);
      end else begin
        rem_nxt = g_rem;
        buf_nxt = g_buf;
        cnt_nxt = g_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 2'd0;
      buf_r       <= 32'h0;
      cnt_r       <= 3'd0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      buf_r       <= buf_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_rem_needs_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 2'd0) |-> ((cnt_r >= 3'd1) && (cnt_r <= 3'd3)))
    else $error("bytes pending without a gathered lead");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + {2'b00, rem_r}) <= 4'd4)
    else $error("gathered plus pending exceeds four bytes");

  a_out_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.symbol_length >= 3'd1) &&
                     (out_data_r.symbol_length <= 3'd4)))
    else $error("emitted symbol length out of range");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last) |=> ((cnt_r == 3'd0) && (rem_r == 2'd0) &&
                           (col_r == '0) && (row_r == '0)))
    else $error("end of text did not clear state");
`endif

endmodule
